[rtl/iowait_boost_ema_util_conditioner_unit_macros.svh]
// assertion macros shared by the conditioner rtl
`ifndef IOWAIT_BOOST_EMA_UTIL_CONDITIONER_UNIT_MACROS_SVH
`define IOWAIT_BOOST_EMA_UTIL_CONDITIONER_UNIT_MACROS_SVH

// condition holds in the same cycle as its trigger
`define IBC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the cycle after its trigger
`define IBC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ibc_pkg.sv]
// package with widths, constants and types of the iowait boost conditioner
package ibc_pkg;

   // capacity scale is 1 << CAPACITY_SHIFT
   localparam int CAPACITY_SHIFT = 10;

   localparam int STAMP_W = 63;
   localparam int UTIL_W  = 11;
   localparam int SHIFT_W = 4;
   localparam int TICK_W  = 27;
   localparam int CSR_W   = 27;
   localparam int CSR_IDX_W = 2;

   // boost level holds values up to the full capacity scale
   localparam int LEVEL_W = CAPACITY_SHIFT + 1;
   localparam int PROD_W  = LEVEL_W + UTIL_W;
   localparam int HI_W    = PROD_W - CAPACITY_SHIFT;

   localparam logic [LEVEL_W-1:0] CAP_SCALE   = LEVEL_W'(1) << CAPACITY_SHIFT;
   localparam logic [LEVEL_W-1:0] BOOST_FLOOR = CAP_SCALE >> 3;
   localparam logic [UTIL_W-1:0]  UTIL_MAX    = {UTIL_W{1'b1}};

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_SHIFT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_SHIFT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_LEN   = 2'd2;

   localparam logic [SHIFT_W-1:0] RISE_SHIFT_RST = 4'd0;
   localparam logic [SHIFT_W-1:0] FALL_SHIFT_RST = 4'd3;
   localparam logic [TICK_W-1:0]  TICK_LEN_RST   = 27'd4000000;

   // iowait boost state
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               pending;
   } boost_state_type;

endpackage

[rtl/ibc_if.sv]
// handshake interfaces for the update and result channels
interface ibc_req_if;
   logic                        valid;
   logic                        ready;
   logic [ibc_pkg::STAMP_W-1:0] stamp_ns;
   logic                        iowait_flag;
   logic [ibc_pkg::UTIL_W-1:0]  sched_util;
   logic [ibc_pkg::UTIL_W-1:0]  cpu_capacity;

   modport source (output valid, stamp_ns, iowait_flag, sched_util, cpu_capacity,
                   input ready);
   modport sink (input valid, stamp_ns, iowait_flag, sched_util, cpu_capacity,
                 output ready);
endinterface

interface ibc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [ibc_pkg::UTIL_W-1:0] ema_util;
   logic [ibc_pkg::UTIL_W-1:0] boost_util;

   modport source (output valid, ema_util, boost_util, input ready);
   modport sink (input valid, ema_util, boost_util, output ready);
endinterface

[rtl/ibc_boost.sv]
// iowait boost update: gap test, level step, decay and capacity scaling
module ibc_boost (
   input  logic [ibc_pkg::STAMP_W-1:0] now,
   input  logic [ibc_pkg::STAMP_W-1:0] last_stamp,
   input  logic [ibc_pkg::TICK_W-1:0]  tick_len,
   input  logic                        iowait,
   input  logic [ibc_pkg::UTIL_W-1:0]  cap,
   input  ibc_pkg::boost_state_type    state_cur,
   output ibc_pkg::boost_state_type    state_nxt,
   output logic [ibc_pkg::UTIL_W-1:0]  boost_util
);

   logic [ibc_pkg::STAMP_W:0]     delta;
   logic                          gap;
   logic [ibc_pkg::LEVEL_W:0]     dbl;
   logic [ibc_pkg::LEVEL_W-1:0]   lvl1;
   logic                          pnd1;
   logic [ibc_pkg::LEVEL_W-1:0]   half;
   logic [ibc_pkg::LEVEL_W-1:0]   lvl2;
   logic                          pnd2;
   logic                          active;
   logic [ibc_pkg::PROD_W-1:0]    prod;
   logic [ibc_pkg::HI_W-1:0]      prod_hi;

   // gap: time moved forward by more than one tick; backwards never counts
   assign delta = {1'b0, now} - {1'b0, last_stamp};
   assign gap   = !delta[ibc_pkg::STAMP_W] &&
                  (delta[ibc_pkg::STAMP_W-1:0] > ibc_pkg::STAMP_W'(tick_len));

   assign dbl  = {state_cur.level, 1'b0};
   assign half = lvl1 >> 1;

   // boost step: gap re-arm, else start or double on a fresh iowait
   always_comb begin
      lvl1 = state_cur.level;
      pnd1 = state_cur.pending;
      if ((state_cur.level != '0) && gap) begin
         lvl1 = iowait ? ibc_pkg::BOOST_FLOOR : '0;
         pnd1 = iowait;
      end else if (iowait && !state_cur.pending) begin
         pnd1 = 1'b1;
         if (state_cur.level != '0) begin
            lvl1 = (dbl > (ibc_pkg::LEVEL_W + 1)'(ibc_pkg::CAP_SCALE)) ?
                   ibc_pkg::CAP_SCALE : dbl[ibc_pkg::LEVEL_W-1:0];
         end else begin
            lvl1 = ibc_pkg::BOOST_FLOOR;
         end
      end
   end

   // boost apply: the second gap test clears, otherwise decay when not pending, else clear pending
   always_comb begin
      lvl2   = lvl1;
      pnd2   = pnd1;
      active = 1'b0;
      if (lvl1 != '0) begin
         if (gap) begin
            lvl2 = '0;
            pnd2 = 1'b0;
         end else if (!pnd1) begin
            if (half < ibc_pkg::BOOST_FLOOR) begin
               lvl2 = '0;
            end else begin
               lvl2   = half;
               active = 1'b1;
            end
         end else begin
            pnd2   = 1'b0;
            active = 1'b1;
         end
      end
   end

   assign state_nxt.level   = lvl2;
   assign state_nxt.pending = pnd2;

   // scale by capacity and saturate to the field
   assign prod    = ibc_pkg::PROD_W'(lvl2) * ibc_pkg::PROD_W'(cap);
   assign prod_hi = prod[ibc_pkg::PROD_W-1:ibc_pkg::CAPACITY_SHIFT];

   always_comb begin
      boost_util = '0;
      if (active) begin
         boost_util = (prod_hi > ibc_pkg::HI_W'(ibc_pkg::UTIL_MAX)) ?
                      ibc_pkg::UTIL_MAX : prod_hi[ibc_pkg::UTIL_W-1:0];
      end
   end

endmodule

[rtl/ibc_ema.sv]
// directional ema step with separate rise and fall shifts
module ibc_ema (
   input  logic [ibc_pkg::UTIL_W-1:0]  prev,
   input  logic [ibc_pkg::UTIL_W-1:0]  sample,
   input  logic [ibc_pkg::SHIFT_W-1:0] rise_shift,
   input  logic [ibc_pkg::SHIFT_W-1:0] fall_shift,
   output logic [ibc_pkg::UTIL_W-1:0]  ema_nxt
);

   logic [ibc_pkg::UTIL_W-1:0] up_diff;
   logic [ibc_pkg::UTIL_W-1:0] dn_diff;
   logic [ibc_pkg::UTIL_W-1:0] dn_mask;
   logic [ibc_pkg::UTIL_W-1:0] dn_step;

   assign up_diff = sample - prev;
   assign dn_diff = prev - sample;

   // falling step rounds up so the value always moves
   assign dn_mask = ~(ibc_pkg::UTIL_MAX << fall_shift);
   assign dn_step = (dn_diff >> fall_shift) +
                    ibc_pkg::UTIL_W'((dn_diff & dn_mask) != '0);

   // unseeded value takes the sample as it is
   always_comb begin
      if (prev == '0) begin
         ema_nxt = sample;
      end else if (sample >= prev) begin
         ema_nxt = prev + (up_diff >> rise_shift);
      end else begin
         ema_nxt = prev - dn_step;
      end
   end

endmodule

[rtl/iowait_boost_ema_util_conditioner_unit.sv]
// top level of the iowait boost and directional ema utilisation conditioner
//
//   channel   dir   handshake        word
//   req_if    in    valid / ready    stamp_ns, iowait_flag, sched_util, cpu_capacity
//   rsp_if    out   valid / ready    ema_util, boost_util
//   csr_*     in    csr_wr_en        csr_index, csr_wdata
//
// one word per cycle sustained unless the result stalls; an accepted word passes through
// the input register, then boost and ema logic, into the result register
// the boost state and ema value update as the word enters the result register
// a stalled result holds the pipe; the input register still takes one more word
// synchronous active high reset clears the state and loads register defaults
`include "iowait_boost_ema_util_conditioner_unit_macros.svh"

module iowait_boost_ema_util_conditioner_unit (
   input  logic                          clock,
   input  logic                          reset,
   ibc_req_if.sink                       req_if,
   ibc_rsp_if.source                     rsp_if,
   input  logic                          csr_wr_en,
   input  logic [ibc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ibc_pkg::CSR_W-1:0]     csr_wdata
);

   logic [ibc_pkg::SHIFT_W-1:0] rise_shift_ff;
   logic [ibc_pkg::SHIFT_W-1:0] fall_shift_ff;
   logic [ibc_pkg::TICK_W-1:0]  tick_len_ff;

   logic                        in_valid_ff, in_valid_in;
   logic [ibc_pkg::STAMP_W-1:0] stamp_ff;
   logic                        iowait_ff;
   logic [ibc_pkg::UTIL_W-1:0]  util_ff;
   logic [ibc_pkg::UTIL_W-1:0]  cap_ff;

   logic                        out_valid_ff, out_valid_in;
   logic [ibc_pkg::UTIL_W-1:0]  smoothed_ff;
   logic [ibc_pkg::UTIL_W-1:0]  boost_ff;

   ibc_pkg::boost_state_type    bst_ff, bst_in;
   logic [ibc_pkg::STAMP_W-1:0] last_stamp_ff;
   logic [ibc_pkg::UTIL_W-1:0]  ema_ff, ema_in;

   logic                        advance;
   logic                        fire;
   logic                        take;
   logic [ibc_pkg::UTIL_W-1:0]  boost_util;
   logic [ibc_pkg::UTIL_W-1:0]  sample;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rise_shift_ff <= ibc_pkg::RISE_SHIFT_RST;
         fall_shift_ff <= ibc_pkg::FALL_SHIFT_RST;
         tick_len_ff   <= ibc_pkg::TICK_LEN_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ibc_pkg::CSR_RISE_SHIFT: rise_shift_ff <= csr_wdata[ibc_pkg::SHIFT_W-1:0];
            ibc_pkg::CSR_FALL_SHIFT: fall_shift_ff <= csr_wdata[ibc_pkg::SHIFT_W-1:0];
            ibc_pkg::CSR_TICK_LEN:   tick_len_ff   <= csr_wdata[ibc_pkg::TICK_W-1:0];
            default: ;
         endcase
      end
   end

   // pipe control
   assign advance      = !out_valid_ff || rsp_if.ready;
   assign fire         = in_valid_ff && advance;
   assign req_if.ready = !in_valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;
   assign in_valid_in  = take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (take) begin
         stamp_ff  <= req_if.stamp_ns;
         iowait_ff <= req_if.iowait_flag;
         util_ff   <= req_if.sched_util;
         cap_ff    <= req_if.cpu_capacity;
      end
   end

   // boost logic
   ibc_boost u_boost (
      .now        (stamp_ff),
      .last_stamp (last_stamp_ff),
      .tick_len   (tick_len_ff),
      .iowait     (iowait_ff),
      .cap        (cap_ff),
      .state_cur  (bst_ff),
      .state_nxt  (bst_in),
      .boost_util (boost_util)
   );

   assign sample = (boost_util > util_ff) ? boost_util : util_ff;

   // ema logic
   ibc_ema u_ema (
      .prev       (ema_ff),
      .sample     (sample),
      .rise_shift (rise_shift_ff),
      .fall_shift (fall_shift_ff),
      .ema_nxt    (ema_in)
   );

   // block state, updated as a word is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         bst_ff        <= '0;
         last_stamp_ff <= '0;
         ema_ff        <= '0;
      end else if (fire) begin
         bst_ff        <= bst_in;
         last_stamp_ff <= stamp_ff;
         ema_ff        <= ema_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (fire) begin
         smoothed_ff <= ema_in;
         boost_ff    <= boost_util;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.ema_util   = smoothed_ff;
   assign rsp_if.boost_util = boost_ff;

   // checks on pipe control and boost state
   `IBC_ASSERT_NEXT(a_fire_fills_out, clock, reset, fire, out_valid_ff, "processed word lost")
   `IBC_ASSERT_NOW(a_stall_means_full, clock, reset, !req_if.ready,
      in_valid_ff && out_valid_ff, "input stalled with room in the pipe")
   `IBC_ASSERT_NOW(a_level_max, clock, reset, 1'b1, bst_ff.level <= ibc_pkg::CAP_SCALE,
      "boost level above capacity scale")
   `IBC_ASSERT_NOW(a_level_floor, clock, reset, bst_ff.level != '0,
      bst_ff.level >= ibc_pkg::BOOST_FLOOR, "boost level below floor")

endmodule
